FILE: sv/pulse_oximeter_beat_detector_unit_macros.svh
// Assertion macros for the beat detector checker.
// Depends on nothing; included by the checker file only.
`ifndef PULSE_OXIMETER_BEAT_DETECTOR_UNIT_MACROS_SVH
`define PULSE_OXIMETER_BEAT_DETECTOR_UNIT_MACROS_SVH

// Clocked assertion, disabled while reset is active.
`define POBD_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define POBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pobd_pkg.sv
// Shared types, constants and helpers of the beat detector.
// Used by the top level, the sequencer and the datapath; depends on nothing.
`timescale 1ns / 1ps

package pobd_pkg;

	localparam int MEAN_DEPTH_DEF = 15;
	localparam int RATE_DEPTH_DEF = 10;

	localparam logic [15:0] DC_ALPHA_RST  = 16'd62259;
	localparam logic [15:0] MIN_LEVEL_RST = 16'd100;
	localparam logic [15:0] MAX_LEVEL_RST = 16'd2000;

	localparam logic [1:0] REG_DC_ALPHA  = 2'd0;
	localparam logic [1:0] REG_MIN_LEVEL = 2'd1;
	localparam logic [1:0] REG_MAX_LEVEL = 2'd2;

	localparam logic [40:0] DC_MAX = {41{1'b1}} >> 1;

	localparam logic signed [16:0] LP_B = 17'sd16072;
	localparam logic signed [16:0] LP_A = 17'sd33392;

	localparam logic [31:0] RATE_NUM = 32'd3840000000;
	localparam logic [15:0] RATE_LO  = 16'd17920;
	localparam logic [15:0] RATE_HI  = 16'd51200;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_RISE = 2'd1;
	localparam logic [1:0] PH_FALL = 2'd2;

	localparam logic [1:0] DIV_MEAN = 2'd0;
	localparam logic [1:0] DIV_RATE = 2'd1;

	typedef struct packed {
		logic [15:0] dc_alpha;
		logic [15:0] min_level;
		logic [15:0] max_level;
	} cfg_t;

	typedef struct packed {
		logic       load_in;
		logic       dc_mul;
		logic       dc_upd;
		logic       mean_upd;
		logic       div_start;
		logic [1:0] div_sel;
		logic       diff_ld;
		logic       lp_b;
		logic       lp_a;
		logic       lp_sum;
		logic       detect;
		logic       rate_upd;
		logic       avg_ld;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic rate_go;
		logic avg_go;
		logic out_busy;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

FILE: sv/pobd_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module pobd_div #(
	parameter int DW = 37
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (fits)
				rem_q <= DW'(shifted - {1'b0, dvs_q});
			else
				rem_q <= shifted[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/pobd_ctrl.sv
// Sequencer of the beat detector: steps one sample through the datapath.
// Depends on pobd_pkg for the command and status structs.
`timescale 1ns / 1ps

module pobd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  pobd_pkg::sts_t sts,
	output logic           in_ready,
	output pobd_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DCMUL = 4'd1;
	localparam logic [3:0] S_DCUPD = 4'd2;
	localparam logic [3:0] S_MEAN  = 4'd3;
	localparam logic [3:0] S_MDIV  = 4'd4;
	localparam logic [3:0] S_MWAIT = 4'd5;
	localparam logic [3:0] S_LPB   = 4'd6;
	localparam logic [3:0] S_LPA   = 4'd7;
	localparam logic [3:0] S_LPSUM = 4'd8;
	localparam logic [3:0] S_DET   = 4'd9;
	localparam logic [3:0] S_DCHK  = 4'd10;
	localparam logic [3:0] S_RWAIT = 4'd11;
	localparam logic [3:0] S_RCHK  = 4'd12;
	localparam logic [3:0] S_OUT   = 4'd14;

	logic [3:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = pobd_pkg::DIV_MEAN;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DCMUL;
				end
			end
			S_DCMUL: begin
				cmd.dc_mul = 1'b1;
				state_d = S_DCUPD;
			end
			S_DCUPD: begin
				cmd.dc_upd = 1'b1;
				state_d = S_MEAN;
			end
			S_MEAN: begin
				cmd.mean_upd = 1'b1;
				state_d = S_MDIV;
			end
			S_MDIV: begin
				cmd.div_start = 1'b1;
				state_d = S_MWAIT;
			end
			S_MWAIT: begin
				if (sts.div_done) begin
					cmd.diff_ld = 1'b1;
					state_d = S_LPB;
				end
			end
			S_LPB: begin
				cmd.lp_b = 1'b1;
				state_d = S_LPA;
			end
			S_LPA: begin
				cmd.lp_a = 1'b1;
				state_d = S_LPSUM;
			end
			S_LPSUM: begin
				cmd.lp_sum = 1'b1;
				state_d = S_DET;
			end
			S_DET: begin
				cmd.detect = 1'b1;
				state_d = S_DCHK;
			end
			S_DCHK: begin
				if (sts.rate_go) begin
					cmd.div_start = 1'b1;
					cmd.div_sel = pobd_pkg::DIV_RATE;
					state_d = S_RWAIT;
				end else begin
					state_d = S_OUT;
				end
			end
			S_RWAIT: begin
				if (sts.div_done) begin
					cmd.rate_upd = 1'b1;
					state_d = S_RCHK;
				end
			end
			S_RCHK: begin
				// the window average is a reciprocal multiply, done in this step
				if (sts.avg_go)
					cmd.avg_ld = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;

endmodule

FILE: sv/pobd_dpath.sv
// Datapath of the beat detector: DC filter, running mean, low pass,
// peak detector, rate window and output register. Depends on pobd_pkg and pobd_div.
`timescale 1ns / 1ps

module pobd_dpath #(
	parameter int MEAN_DEPTH = pobd_pkg::MEAN_DEPTH_DEF,
	parameter int RATE_DEPTH = pobd_pkg::RATE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pobd_pkg::cfg_t cfg,
	input  pobd_pkg::cmd_t cmd,
	output pobd_pkg::sts_t sts,
	input  logic [15:0]    raw_ir,
	input  logic [31:0]    time_us,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [128:0]   out_data
);

	localparam int SUM_W = 33 + $clog2(MEAN_DEPTH);
	localparam int DW    = (SUM_W > 32) ? SUM_W : 32;
	localparam int AW    = SUM_W + 1;
	localparam int PW    = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
	localparam int FW    = $clog2(MEAN_DEPTH + 1);
	localparam int RPW   = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
	localparam int RFW   = $clog2(RATE_DEPTH + 1);
	localparam int RSW   = 16 + $clog2(RATE_DEPTH + 1);
	// window average by reciprocal: exact for every sum below 2^RSW
	localparam int RSH   = RSW + 6;
	localparam logic [RSH-1:0] RCP = RSH'((2 ** RSH + RATE_DEPTH - 1) / RATE_DEPTH);

	localparam logic signed [48:0] LP_B_EXT = 49'(pobd_pkg::LP_B);
	localparam logic signed [48:0] LP_A_EXT = 49'(pobd_pkg::LP_A);

	// input capture and DC filter
	logic [15:0] x_q;
	logic [31:0] now_q;
	logic [40:0] dc_q;
	logic [56:0] dc_prod_q;
	logic signed [31:0] ac_q, dc_lvl_q;
	logic [56:0] dc_rnd;
	logic [41:0] wsum;
	logic [40:0] w;
	logic signed [41:0] wdiff;

	assign dc_rnd = (dc_prod_q + 57'd32768) >> 16;
	assign wsum   = {10'd0, x_q, 16'd0} + {1'b0, dc_rnd[40:0]};
	assign w      = (wsum > {1'b0, pobd_pkg::DC_MAX}) ? pobd_pkg::DC_MAX : wsum[40:0];
	assign wdiff  = $signed({1'b0, w}) - $signed({1'b0, dc_q});

	// running mean
	logic signed [31:0]    win_q [MEAN_DEPTH];
	logic signed [SUM_W-1:0] msum_q;
	logic [PW-1:0]         pos_q;
	logic [FW-1:0]         fill_q;
	logic signed [SUM_W-1:0] msum_d;

	assign msum_d = msum_q - SUM_W'(win_q[pos_q]) + SUM_W'(ac_q);

	// low pass
	logic signed [31:0] diff_q, lp_prev_q, card_q;
	logic signed [48:0] prodb_q, proda_q;
	logic signed [49:0] lp_t;
	logic signed [31:0] v1;
	logic signed [AW-1:0] avg;

	assign lp_t = 50'(prodb_q) + 50'(proda_q) + 50'sd32768;
	assign v1   = pobd_pkg::sat32(64'(lp_t >>> 16));

	// peak detector
	logic [1:0]         phase_q;
	logic signed [31:0] prior_q;
	logic [31:0]        peak_t_q, prior_t_q, interval_q;
	logic [15:0]        held_q;
	logic               beat_q, rate_go_q, avg_go_q;
	logic [32:0]        mag;
	logic               abort, above_lo, beat_now;

	assign mag      = card_q[31] ? 33'(-34'(card_q)) : 33'(card_q);
	assign abort    = mag > {1'b0, cfg.max_level, 16'd0};
	assign above_lo = 34'(card_q) >= $signed({2'b0, cfg.min_level, 16'd0});
	assign beat_now = phase_q == pobd_pkg::PH_RISE && !(card_q > prior_q);

	// rate window
	logic [15:0]    rwin_q [RATE_DEPTH];
	logic [RSW-1:0] rsum_q;
	logic [RFW-1:0] rfill_q;
	logic [15:0]    ravg_q;
	logic [15:0]    raw;
	logic [15:0]    rtmp [RATE_DEPTH];
	logic [RSW-1:0] rsum_d;
	logic           append, shift;
	logic [RSW+RSH-1:0] avg_prod;

	assign avg_prod = rsum_q * RCP;

	// divider, shared by the mean and the beat rate
	logic [DW-1:0] div_a, div_b, quo;
	logic          div_done;
	logic [SUM_W-1:0] msum_mag;

	assign msum_mag = msum_q[SUM_W-1] ? SUM_W'(-msum_q) : SUM_W'(msum_q);

	always_comb begin
		unique case (cmd.div_sel)
			pobd_pkg::DIV_MEAN: begin
				div_a = DW'(msum_mag);
				div_b = DW'(fill_q);
			end
			pobd_pkg::DIV_RATE: begin
				div_a = DW'(pobd_pkg::RATE_NUM);
				div_b = DW'(interval_q);
			end
			default: begin
				div_a = '0;
				div_b = DW'(1);
			end
		endcase
	end

	pobd_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quo)
	);

	assign avg = msum_q[SUM_W-1] ? -$signed({1'b0, quo[SUM_W-1:0]})
	                             : $signed({1'b0, quo[SUM_W-1:0]});

	assign raw = (quo > DW'(16'hFFFF)) ? 16'hFFFF : quo[15:0];

	always_comb begin
		append = rfill_q < RFW'(RATE_DEPTH);
		shift  = (append ? (rfill_q == RFW'(RATE_DEPTH - 1)) : 1'b1)
		         && raw > pobd_pkg::RATE_LO && raw < pobd_pkg::RATE_HI;
		rtmp   = rwin_q;
		rsum_d = rsum_q;
		if (append) begin
			rtmp[rfill_q[RPW-1:0]] = raw;
			rsum_d = rsum_d + RSW'(raw);
		end
		if (shift) begin
			rsum_d = rsum_d - RSW'(rtmp[0]) + RSW'(raw);
			for (int i = 0; i < RATE_DEPTH - 1; i++)
				rtmp[i] = rtmp[i + 1];
			rtmp[RATE_DEPTH - 1] = raw;
		end
	end

	// output register
	logic out_valid_q;
	logic [128:0] out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q      <= '0;
			msum_q    <= '0;
			pos_q     <= '0;
			fill_q    <= '0;
			lp_prev_q <= '0;
			phase_q   <= pobd_pkg::PH_IDLE;
			prior_q   <= '0;
			peak_t_q  <= '0;
			prior_t_q <= '0;
			interval_q <= '0;
			held_q    <= '0;
			rsum_q    <= '0;
			rfill_q   <= '0;
			ravg_q    <= '0;
			beat_q    <= 1'b0;
			rate_go_q <= 1'b0;
			avg_go_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MEAN_DEPTH; i++)
				win_q[i] <= '0;
			for (int i = 0; i < RATE_DEPTH; i++)
				rwin_q[i] <= '0;
		end else begin
			if (cmd.dc_upd)
				dc_q <= w;
			if (cmd.mean_upd) begin
				msum_q <= msum_d;
				win_q[pos_q] <= ac_q;
				pos_q <= (pos_q == PW'(MEAN_DEPTH - 1)) ? '0 : pos_q + 1'b1;
				if (fill_q < FW'(MEAN_DEPTH))
					fill_q <= fill_q + 1'b1;
			end
			if (cmd.lp_sum)
				lp_prev_q <= v1;
			if (cmd.detect) begin
				beat_q    <= !abort && beat_now;
				rate_go_q <= !abort && beat_now && peak_t_q != prior_t_q;
				avg_go_q  <= 1'b0;
				if (abort) begin
					phase_q   <= pobd_pkg::PH_IDLE;
					prior_q   <= '0;
					peak_t_q  <= '0;
					prior_t_q <= '0;
					held_q    <= '0;
				end else begin
					// hold the last level on the beat sample
					if (!beat_now)
						prior_q <= card_q;
					unique case (phase_q)
						pobd_pkg::PH_IDLE: begin
							if (above_lo)
								phase_q <= pobd_pkg::PH_RISE;
						end
						pobd_pkg::PH_RISE: begin
							if (!beat_now) begin
								peak_t_q <= now_q;
								held_q   <= card_q[31] ? 16'd0 : card_q[31:16];
							end else begin
								interval_q <= peak_t_q - prior_t_q;
								prior_t_q  <= peak_t_q;
								phase_q    <= pobd_pkg::PH_FALL;
							end
						end
						default: begin
							if (!above_lo)
								phase_q <= pobd_pkg::PH_IDLE;
						end
					endcase
				end
			end
			if (cmd.rate_upd) begin
				rwin_q   <= rtmp;
				rsum_q   <= rsum_d;
				avg_go_q <= shift;
				if (append)
					rfill_q <= rfill_q + 1'b1;
			end
			if (cmd.avg_ld)
				ravg_q <= avg_prod[RSH +: 16];
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q   <= raw_ir;
			now_q <= time_us;
		end
		if (cmd.dc_mul)
			dc_prod_q <= dc_q * cfg.dc_alpha;
		if (cmd.dc_upd) begin
			ac_q     <= pobd_pkg::sat32(64'(wdiff));
			dc_lvl_q <= (w > 41'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(w[31:0]);
		end
		if (cmd.diff_ld)
			diff_q <= pobd_pkg::sat32(64'(avg) - 64'(ac_q));
		if (cmd.lp_b)
			prodb_q <= LP_B_EXT * 49'(diff_q);
		if (cmd.lp_a)
			proda_q <= LP_A_EXT * 49'(lp_prev_q);
		if (cmd.lp_sum)
			card_q <= pobd_pkg::sat32(64'(lp_prev_q) + 64'(v1));
		if (cmd.out_ld)
			out_q <= {held_q, ac_q, dc_lvl_q, card_q, ravg_q, beat_q};
	end

	assign sts.div_done = div_done;
	assign sts.rate_go  = rate_go_q;
	assign sts.avg_go   = avg_go_q;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

FILE: sv/pulse_oximeter_beat_detector_unit.sv
// Top level of the PPG beat detector: stream ports, APB register file,
// sequencer and datapath. Depends on pobd_pkg, pobd_ctrl and pobd_dpath.
`timescale 1ns / 1ps

// One IR sample with its microsecond timestamp enters per slave beat and one
// result leaves per master beat. The block works on one sample at a time and
// takes no new sample until the last one has reached the output register.
// The shared bit-serial divider is DW = max(33 + clog2(MEAN_DEPTH), 32) bits
// wide. A sample that ends a beat with a nonzero interval adds one more
// division for the rate plus one step for the window update. The window
// average is a reciprocal multiply and costs no division. The running-mean
// divide and the rate divide share the one divider.
// The finished result waits in an output register, so the slave side takes
// the next sample while it is unread; the block stalls only when a new result
// is ready and the old one is still not taken. Registers: dc_alpha at 0x0,
// pulse_min_level at 0x4, pulse_max_level at 0x8; write them only while the
// block is idle.
module pulse_oximeter_beat_detector_unit #(
	parameter int MEAN_DEPTH = pobd_pkg::MEAN_DEPTH_DEF,
	parameter int RATE_DEPTH = pobd_pkg::RATE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// APB configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	// sample input
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [47:0]  s_tdata,   // raw_ir[15:0], time_us[47:16]
	// result output
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata    // beat_found[0], heart_rate[16:1], cardiogram[48:17],
	                                // ir_dc_level[80:49], ir_ac_value[112:81],
	                                // peak_level[128:113], zero fill above
);

	pobd_pkg::cfg_t cfg_q;
	pobd_pkg::cmd_t cmd;
	pobd_pkg::sts_t sts;
	logic [128:0]   res;
	logic           wr_en;

	// Register write lands on the access phase; pready is tied high.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dc_alpha  <= pobd_pkg::DC_ALPHA_RST;
			cfg_q.min_level <= pobd_pkg::MIN_LEVEL_RST;
			cfg_q.max_level <= pobd_pkg::MAX_LEVEL_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				pobd_pkg::REG_DC_ALPHA:  cfg_q.dc_alpha  <= pwdata[15:0];
				pobd_pkg::REG_MIN_LEVEL: cfg_q.min_level <= pwdata[15:0];
				pobd_pkg::REG_MAX_LEVEL: cfg_q.max_level <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register; unmapped addresses read zero.
	always_comb begin
		unique case (paddr[3:2])
			pobd_pkg::REG_DC_ALPHA:  prdata = {16'd0, cfg_q.dc_alpha};
			pobd_pkg::REG_MIN_LEVEL: prdata = {16'd0, cfg_q.min_level};
			pobd_pkg::REG_MAX_LEVEL: prdata = {16'd0, cfg_q.max_level};
			default:                 prdata = '0;
		endcase
	end

	// Sequencer: advance one sample through the datapath steps.
	pobd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	// Datapath: filters, detector, rate window and the output register.
	pobd_dpath #(
		.MEAN_DEPTH (MEAN_DEPTH),
		.RATE_DEPTH (RATE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.raw_ir    (s_tdata[15:0]),
		.time_us   (s_tdata[47:16]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (res)
	);

	assign m_tdata = {7'd0, res};

endmodule

FILE: sv/pobd_checker.sv
// Port-level checker of the beat detector, bound to the top level.
// Depends on the macro header and the top level's ports.
`timescale 1ns / 1ps
`include "pulse_oximeter_beat_detector_unit_macros.svh"

module pobd_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         psel,
	input logic         penable,
	input logic         pwrite,
	input logic [3:0]   paddr,
	input logic [31:0]  pwdata,
	input logic [31:0]  prdata,
	input logic         pready,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [135:0] m_tdata
);

	`POBD_ASSERT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "sample accepted while busy")
	`POBD_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
	`POBD_ASSERT(a_readback, clk, arst_n, (psel && penable && pwrite && paddr == 4'd0) ##1 (psel && !pwrite && paddr == 4'd0) |-> prdata[15:0] == $past(pwdata[15:0]) && prdata[31:16] == 16'd0, "register readback mismatch")
	`POBD_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")

endmodule

bind pulse_oximeter_beat_detector_unit pobd_checker u_pobd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata),
	.pready   (pready),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
